// ===== src/rtce_pkg.sv =====
// rtce_pkg: shared types, constants and helpers for the RTC BCD time to
// epoch seconds core. No dependencies; imported by rtce_decode and the top.
`timescale 1ns / 1ps

package rtce_pkg;

  // pipeline depth of the core (register stages, output stage included)
  localparam int NSTG = 6;

  localparam logic [15:0] YEAR_EPOCH  = 16'd1970;
  localparam logic [14:0] LEAPS_1969  = 15'd477;   // leap years in 1..1969
  localparam logic [31:0] DAY_SEC     = 32'd86400;
  localparam logic [19:0] HOUR_SEC    = 20'd3600;
  localparam logic [19:0] MIN_SEC     = 20'd60;

  // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT, exact for n < 43690
  localparam int          RECIP_SHIFT = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          YR_W        = 15;          // year value width
  localparam int          PROD_W      = YR_W + 13;
  localparam int          Q_W         = PROD_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    REG_BCD_MODE      = 2'd0,
    REG_TWELVE_HOUR   = 2'd1,
    REG_CENTURY_VALID = 2'd2,
    REG_BASE_YEAR     = 2'd3
  } cfg_reg_e_t;

  typedef struct packed {
    logic        bcd_mode;
    logic        twelve_hour_mode;
    logic        century_valid;
    logic [13:0] base_year;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  weekday;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] full_year;
  } fields_t;

  // hi*10 + lo, nibbles above 9 taken as they are (max 165)
  function automatic logic [7:0] nibble_pair_value(input logic [7:0] v);
    return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
  endfunction

  function automatic logic [7:0] dec_byte(input logic bcd, input logic [7:0] v);
    return bcd ? nibble_pair_value(v) : v;
  endfunction

  // days before month (idx = month - 1), idx 12 is a full year
  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/rtce_decode.sv =====
// rtce_decode: front-end decode of one raw RTC snapshot (BCD, 12-hour
// hours, full year). Combinational; depends on rtce_pkg.
`timescale 1ns / 1ps

module rtce_decode (
  input  rtce_pkg::cfg_t    cfg,
  input  logic [7:0]        raw_second,
  input  logic [7:0]        raw_minute,
  input  logic [7:0]        raw_hour,
  input  logic [7:0]        raw_weekday,
  input  logic [7:0]        raw_day,
  input  logic [7:0]        raw_month,
  input  logic [7:0]        raw_year,
  input  logic [7:0]        raw_century,
  output rtce_pkg::fields_t fld
);
  import rtce_pkg::*;

  logic [7:0]  hr_src;
  logic        pm;
  logic [7:0]  hr_dec;
  logic [7:0]  hr_12;
  logic [7:0]  yr2;
  logic [7:0]  cent;
  logic [15:0] cent_x100;

  always_comb begin
    // PM flag is only meaningful in 12-hour mode
    pm     = cfg.twelve_hour_mode & raw_hour[7];
    hr_src = cfg.twelve_hour_mode ? {1'b0, raw_hour[6:0]} : raw_hour;
    hr_dec = dec_byte(cfg.bcd_mode, hr_src);
    hr_12  = (hr_dec == 8'd12) ? 8'd0 : hr_dec;

    yr2       = dec_byte(cfg.bcd_mode, raw_year);
    cent      = dec_byte(cfg.bcd_mode, raw_century);
    cent_x100 = {2'b00, cent, 6'b000000} + {3'b000, cent, 5'b00000}
              + {6'b000000, cent, 2'b00};

    fld.second  = dec_byte(cfg.bcd_mode, raw_second);
    fld.minute  = dec_byte(cfg.bcd_mode, raw_minute);
    fld.weekday = dec_byte(cfg.bcd_mode, raw_weekday);
    fld.day     = dec_byte(cfg.bcd_mode, raw_day);
    fld.month   = dec_byte(cfg.bcd_mode, raw_month);
    if (cfg.twelve_hour_mode) begin
      fld.hour = pm ? hr_12 + 8'd12 : hr_12;
    end else begin
      fld.hour = hr_dec;
    end
    if (cfg.century_valid) begin
      fld.full_year = cent_x100 + {8'h00, yr2};
    end else begin
      fld.full_year = {2'b00, cfg.base_year} + {8'h00, yr2};
    end
  end

endmodule

// ===== src/rtc_bcd_time_to_epoch_seconds_core.sv =====
// rtc_bcd_time_to_epoch_seconds_core: six-stage pipeline from raw RTC bytes
// to decoded fields and Unix seconds. Depends on rtce_pkg and rtce_decode.
// Throughput: one beat per cycle; every stage is one register deep and the
// pipeline only halts when all stages are full and out_stall is high.
// Reset (rst_n low, synchronous): all stage valid bits clear, config
// registers return to bcd_mode=1, twelve_hour_mode=0, century_valid=0,
// base_year=2000.
`timescale 1ns / 1ps

module rtc_bcd_time_to_epoch_seconds_core (
  input  logic        clk,
  input  logic        rst_n,
  // config port (APB-style)
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beat
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_raw_second,
  input  logic [7:0]  in_raw_minute,
  input  logic [7:0]  in_raw_hour,
  input  logic [7:0]  in_raw_weekday,
  input  logic [7:0]  in_raw_day,
  input  logic [7:0]  in_raw_month,
  input  logic [7:0]  in_raw_year,
  input  logic [7:0]  in_raw_century,
  // result beat
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_second,
  output logic [7:0]  out_minute,
  output logic [7:0]  out_hour,
  output logic [7:0]  out_weekday,
  output logic [7:0]  out_day,
  output logic [7:0]  out_month,
  output logic [15:0] out_full_year,
  output logic [31:0] out_epoch_seconds
);
  import rtce_pkg::*;

  // ---------------------------------------------------------------------
  // Config registers. pready is tied high, so a write lands on the access
  // cycle. paddr[3:2] selects the register; all four codes are defined.
  // ---------------------------------------------------------------------
  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       cfg_wr;
  cfg_reg_e_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_BCD_MODE:      cfg_nxt.bcd_mode         = pwdata[0];
        REG_TWELVE_HOUR:   cfg_nxt.twelve_hour_mode = pwdata[0];
        REG_CENTURY_VALID: cfg_nxt.century_valid    = pwdata[0];
        REG_BASE_YEAR:     cfg_nxt.base_year        = pwdata[13:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_BCD_MODE:      prdata = {31'd0, cfg_r.bcd_mode};
      REG_TWELVE_HOUR:   prdata = {31'd0, cfg_r.twelve_hour_mode};
      REG_CENTURY_VALID: prdata = {31'd0, cfg_r.century_valid};
      REG_BASE_YEAR:     prdata = {18'd0, cfg_r.base_year};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bcd_mode         <= 1'b1;
      cfg_r.twelve_hour_mode <= 1'b0;
      cfg_r.century_valid    <= 1'b0;
      cfg_r.base_year        <= 14'd2000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. A stage moves when it is empty or when the
  // stage after it moves; the last stage moves when out_stall is low.
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_in;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign vld_in   = {vld_r[NSTG-2:0], in_valid};
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  // decoded fields ride along every stage
  fields_t dec_fld;
  fields_t fld_r  [NSTG];
  fields_t fld_in [NSTG];

  rtce_decode u_decode (
    .cfg         (cfg_r),
    .raw_second  (in_raw_second),
    .raw_minute  (in_raw_minute),
    .raw_hour    (in_raw_hour),
    .raw_weekday (in_raw_weekday),
    .raw_day     (in_raw_day),
    .raw_month   (in_raw_month),
    .raw_year    (in_raw_year),
    .raw_century (in_raw_century),
    .fld         (dec_fld)
  );

  always_comb begin
    fld_in[0] = dec_fld;
    for (int k = 1; k < NSTG; k++) begin
      fld_in[k] = fld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) begin
        fld_r[k] <= fld_in[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: year >= 1970 check, year offset, and year/100 for both the
  // year and the year before it (reciprocal multiply).
  // ---------------------------------------------------------------------
  logic [YR_W-1:0]   yr1;
  logic [YR_W-1:0]   n1;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_n;
  logic              ge_s1_nxt;
  logic [YR_W-1:0]   yoff_s1_nxt;
  logic              ge_s1_r;
  logic [YR_W-1:0]   yoff_s1_r;
  logic [YR_W-1:0]   n_s1_r;
  logic [Q_W-1:0]    qy_s1_r;
  logic [Q_W-1:0]    qn_s1_r;

  always_comb begin
    // year is below 2^15 in every mode (max 255*100 + 255)
    yr1         = fld_r[0].full_year[YR_W-1:0];
    n1          = yr1 - YR_W'(1);
    prod_y      = PROD_W'(yr1) * PROD_W'(RECIP_100);
    prod_n      = PROD_W'(n1) * PROD_W'(RECIP_100);
    ge_s1_nxt   = fld_r[0].full_year >= YEAR_EPOCH;
    yoff_s1_nxt = yr1 - YEAR_EPOCH[YR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ge_s1_r   <= ge_s1_nxt;
      yoff_s1_r <= yoff_s1_nxt;
      n_s1_r    <= n1;
      qy_s1_r   <= prod_y[PROD_W-1:RECIP_SHIFT];
      qn_s1_r   <= prod_n[PROD_W-1:RECIP_SHIFT];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: leap flag, leap years since 1970, 365 * year offset, and the
  // time-of-day seconds.
  // ---------------------------------------------------------------------
  logic [YR_W-1:0] qy_x100;
  logic            cent_yr;
  logic            leap_s2_nxt;
  logic [YR_W-1:0] leaps_w;
  logic [23:0]     y365_s2_nxt;
  logic [19:0]     hms_s2_nxt;
  logic            ge_s2_r;
  logic            leap_s2_r;
  logic [12:0]     leaps_s2_r;
  logic [23:0]     y365_s2_r;
  logic [19:0]     hms_s2_r;

  always_comb begin
    qy_x100     = YR_W'(qy_s1_r) * YR_W'(100);
    cent_yr     = qy_x100 == fld_r[1].full_year[YR_W-1:0];
    // century years are leap only when year/100 is a multiple of four
    leap_s2_nxt = (fld_r[1].full_year[1:0] == 2'b00 && !cent_yr)
               || (cent_yr && qy_s1_r[1:0] == 2'b00);
    leaps_w     = (n_s1_r >> 2) + YR_W'(qn_s1_r >> 2) - YR_W'(qn_s1_r) - LEAPS_1969;
    y365_s2_nxt = 24'(yoff_s1_r) * 24'd365;
    hms_s2_nxt  = 20'(fld_r[1].hour) * HOUR_SEC + 20'(fld_r[1].minute) * MIN_SEC
                + 20'(fld_r[1].second);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ge_s2_r    <= ge_s1_r;
      leap_s2_r  <= leap_s2_nxt;
      leaps_s2_r <= leaps_w[12:0];
      y365_s2_r  <= y365_s2_nxt;
      hms_s2_r   <= hms_s2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: whole-year days and days before the month. Month 0 adds
  // nothing; months past 13 add a full year plus 30 days each.
  // ---------------------------------------------------------------------
  logic [7:0]  mon3;
  logic [12:0] mdays_s3_nxt;
  logic [23:0] daysy_s3_nxt;
  logic        ge_s3_r;
  logic [23:0] daysy_s3_r;
  logic [12:0] mdays_s3_r;
  logic [19:0] hms_s3_r;

  always_comb begin
    mon3         = fld_r[2].month;
    daysy_s3_nxt = y365_s2_r + 24'(leaps_s2_r);
    if (mon3 == 8'd0) begin
      mdays_s3_nxt = 13'd0;
    end else if (mon3 <= 8'd13) begin
      mdays_s3_nxt = 13'(days_before(4'(mon3 - 8'd1)))
                   + 13'(leap_s2_r && mon3 > 8'd2);
    end else begin
      mdays_s3_nxt = 13'd365 + 13'(leap_s2_r) + 13'(mon3 - 8'd13) * 13'd30;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ge_s3_r    <= ge_s2_r;
      daysy_s3_r <= daysy_s3_nxt;
      mdays_s3_r <= mdays_s3_nxt;
      hms_s3_r   <= hms_s2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: total day count, mod 2^32 (day 0 steps back one day).
  // ---------------------------------------------------------------------
  logic [31:0] days_s4_nxt;
  logic        ge_s4_r;
  logic [31:0] days_s4_r;
  logic [19:0] hms_s4_r;

  assign days_s4_nxt = 32'(daysy_s3_r) + 32'(mdays_s3_r) + 32'(fld_r[3].day) - 32'd1;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ge_s4_r   <= ge_s3_r;
      days_s4_r <= days_s4_nxt;
      hms_s4_r  <= hms_s3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5 (output): days * 86400 + time of day, zero before 1970.
  // ---------------------------------------------------------------------
  logic [31:0] epoch_s5_nxt;
  logic [31:0] epoch_s5_r;

  assign epoch_s5_nxt = ge_s4_r ? days_s4_r * DAY_SEC + 32'(hms_s4_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      epoch_s5_r <= epoch_s5_nxt;
    end
  end

  assign out_valid         = vld_r[NSTG-1];
  assign out_second        = fld_r[NSTG-1].second;
  assign out_minute        = fld_r[NSTG-1].minute;
  assign out_hour          = fld_r[NSTG-1].hour;
  assign out_weekday       = fld_r[NSTG-1].weekday;
  assign out_day           = fld_r[NSTG-1].day;
  assign out_month         = fld_r[NSTG-1].month;
  assign out_full_year     = fld_r[NSTG-1].full_year;
  assign out_epoch_seconds = epoch_s5_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pre_epoch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_year < YEAR_EPOCH |-> out_epoch_seconds == 32'd0)
    else $error("epoch seconds nonzero for year before 1970");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled while pipeline has a free stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !vld_r[NSTG-2] |=> !out_valid)
    else $error("output beat repeated after being taken");

  a_base_year_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_sel == REG_BASE_YEAR |=> cfg_r.base_year == $past(pwdata[13:0]))
    else $error("base_year write not taken");

endmodule

// ===== verif/rtce_tb_pkg.sv =====
// rtce_tb_pkg: snapshot and result types, idle modes and the epoch scoreboard
// used by the RTC BCD to epoch seconds core testbench. Depends on rtce_pkg.
`timescale 1ns / 1ps

package rtce_tb_pkg;

  import rtce_pkg::*;

  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] weekday;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
  } snapshot_t;

  typedef struct packed {
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  weekday;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] full_year;
    logic [31:0] epoch_seconds;
  } decoded_time_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH,
    IDLE_BACKLOG
  } idle_mode_t;

  // days elapsed before the first of each month; last entry is a full year
  localparam int unsigned MONTH_START_DAYS [13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  class epoch_scoreboard;
    cfg_t          cfg;
    decoded_time_t expected_q[$];
    int unsigned   mismatches;

    function new();
      cfg.bcd_mode         = 1'b1;
      cfg.twelve_hour_mode = 1'b0;
      cfg.century_valid    = 1'b0;
      cfg.base_year        = 14'd2000;
      mismatches           = 0;
    endfunction

    function void write_reg(cfg_reg_e_t idx, logic [31:0] value);
      case (idx)
        REG_BCD_MODE:      cfg.bcd_mode         = value[0];
        REG_TWELVE_HOUR:   cfg.twelve_hour_mode = value[0];
        REG_CENTURY_VALID: cfg.century_valid    = value[0];
        REG_BASE_YEAR:     cfg.base_year        = value[13:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] unbcd(logic [7:0] b);
      if (!cfg.bcd_mode) return b;
      return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
    endfunction

    function int unsigned leap_years_upto(int unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function decoded_time_t convert(snapshot_t s);
      decoded_time_t r;
      logic [7:0]    hour_byte;
      logic          pm;
      int unsigned   yr;
      int unsigned   days;
      bit            leap;
      r.second  = unbcd(s.second);
      r.minute  = unbcd(s.minute);
      r.weekday = unbcd(s.weekday);
      r.day     = unbcd(s.day);
      r.month   = unbcd(s.month);
      hour_byte = s.hour;
      pm        = 1'b0;
      if (cfg.twelve_hour_mode) begin
        pm           = hour_byte[7];
        hour_byte[7] = 1'b0;
      end
      r.hour = unbcd(hour_byte);
      if (cfg.twelve_hour_mode) begin
        if (r.hour == 8'd12) r.hour = 8'd0;
        if (pm) r.hour = r.hour + 8'd12;
      end
      if (cfg.century_valid)
        yr = (int'(unbcd(s.century)) * 100 + int'(unbcd(s.year))) & 32'hFFFF;
      else
        yr = (int'(cfg.base_year) + int'(unbcd(s.year))) & 32'hFFFF;
      r.full_year     = 16'(yr);
      r.epoch_seconds = '0;
      if (yr >= 1970) begin
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        days = 365 * (yr - 1970) + leap_years_upto(yr - 1) - leap_years_upto(1969);
        if (r.month >= 1) begin
          if (r.month <= 13) begin
            days += MONTH_START_DAYS[r.month - 1];
            if (leap && r.month > 2) days += 1;
          end else begin
            days += 365 + (leap ? 1 : 0) + 30 * (r.month - 13);
          end
        end
        days = days + r.day - 1;
        r.epoch_seconds = days * 86400 + r.hour * 3600 + r.minute * 60 + r.second;
      end
      return r;
    endfunction

    function void note_snapshot(snapshot_t s);
      expected_q.push_back(convert(s));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(decoded_time_t got);
      decoded_time_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %p", $time, got);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("second", exp_r.second, got.second);
      compare_field("minute", exp_r.minute, got.minute);
      compare_field("hour", exp_r.hour, got.hour);
      compare_field("weekday", exp_r.weekday, got.weekday);
      compare_field("day", exp_r.day, got.day);
      compare_field("month", exp_r.month, got.month);
      compare_field("full_year", exp_r.full_year, got.full_year);
      compare_field("epoch_seconds", exp_r.epoch_seconds, got.epoch_seconds);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== verif/rtc_bcd_time_to_epoch_seconds_core_tb.sv =====
// Testbench for rtc_bcd_time_to_epoch_seconds_core: directed and random RTC
// snapshots under several register settings, checked against the epoch
// scoreboard. Depends on rtce_pkg, rtce_tb_pkg and the core RTL.
`timescale 1ns / 1ps

module rtc_bcd_time_to_epoch_seconds_core_tb;

  import rtce_pkg::*;
  import rtce_tb_pkg::*;

  // comfortable margin for the core to settle after the last result
  localparam int          SETTLE_CYCLES  = 12;
  // long receiver hold-off, enough to fill all six stages many times over
  localparam int          BACKLOG_CYCLES = 300;
  // watchdog limit, far beyond the length of a normal run
  localparam int unsigned CYCLE_LIMIT    = 200000;

  logic        clk;
  logic        rst_n   = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_stall;
  snapshot_t   cur_snap = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_second;
  logic [7:0]  out_minute;
  logic [7:0]  out_hour;
  logic [7:0]  out_weekday;
  logic [7:0]  out_day;
  logic [7:0]  out_month;
  logic [15:0] out_full_year;
  logic [31:0] out_epoch_seconds;

  idle_mode_t  idle_mode   = IDLE_NONE;   // driven by the stimulus thread
  idle_mode_t  seen_mode   = IDLE_NONE;   // receiver's copy, detects phase change
  int          hold_left   = 0;
  int unsigned cycle_count = 0;

  epoch_scoreboard sb;

  rtc_bcd_time_to_epoch_seconds_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_second     (cur_snap.second),
    .in_raw_minute     (cur_snap.minute),
    .in_raw_hour       (cur_snap.hour),
    .in_raw_weekday    (cur_snap.weekday),
    .in_raw_day        (cur_snap.day),
    .in_raw_month      (cur_snap.month),
    .in_raw_year       (cur_snap.year),
    .in_raw_century    (cur_snap.century),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_second        (out_second),
    .out_minute        (out_minute),
    .out_hour          (out_hour),
    .out_weekday       (out_weekday),
    .out_day           (out_day),
    .out_month         (out_month),
    .out_full_year     (out_full_year),
    .out_epoch_seconds (out_epoch_seconds)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Beat monitor. Everything is driven with NBAs at the rising edge, so the
  // values read here are the ones the core sees at this same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_snapshot(cur_snap);
      if (out_valid && !out_stall)
        sb.check_result('{out_second, out_minute, out_hour, out_weekday, out_day,
                          out_month, out_full_year, out_epoch_seconds});
    end
  end

  // Result side back-pressure. A backlog phase opens with a long hold-off
  // counted here, while the sender keeps offering beats, so the pipe fills
  // and in_stall has to rise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (idle_mode != seen_mode) begin
        seen_mode = idle_mode;
        if (idle_mode == IDLE_BACKLOG) hold_left = BACKLOG_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (idle_mode)
          IDLE_RECV: out_stall <= ($urandom_range(99) < 66);
          IDLE_BOTH: out_stall <= ($urandom_range(99) < 25);
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  function automatic bit sender_holds(idle_mode_t mode);
    case (mode)
      IDLE_SEND: return $urandom_range(99) < 66;
      IDLE_BOTH: return $urandom_range(99) < 25;
      default:   return 1'b0;
    endcase
  endfunction

  // Encode a small decimal value the way the RTC would present it now.
  function automatic logic [7:0] rtc_byte(int v);
    return sb.cfg.bcd_mode ? 8'((v / 10) * 16 + v % 10) : 8'(v);
  endfunction

  function automatic snapshot_t snap(logic [7:0] s, logic [7:0] mi, logic [7:0] h,
                                     logic [7:0] w, logic [7:0] d, logic [7:0] mo,
                                     logic [7:0] y, logic [7:0] c);
    return '{s, mi, h, w, d, mo, y, c};
  endfunction

  // A clock reading that a real part could produce, with the odd
  // out-of-range month or a day of zero mixed in.
  function automatic snapshot_t plausible_snapshot();
    snapshot_t s;
    int        mo;
    case ($urandom_range(11))
      0:       mo = 0;
      1:       mo = 13;
      2:       mo = $urandom_range(14, 99);
      default: mo = $urandom_range(1, 12);
    endcase
    s.second  = rtc_byte($urandom_range(59));
    s.minute  = rtc_byte($urandom_range(59));
    if (sb.cfg.twelve_hour_mode)
      s.hour = rtc_byte($urandom_range(1, 12)) | ($urandom_range(1) ? 8'h80 : 8'h00);
    else
      s.hour = rtc_byte($urandom_range(23));
    s.weekday = rtc_byte($urandom_range(1, 7));
    s.day     = ($urandom_range(19) == 0) ? 8'h00 : rtc_byte($urandom_range(1, 31));
    s.month   = rtc_byte(mo);
    s.year    = rtc_byte($urandom_range(99));
    s.century = rtc_byte($urandom_range(19, 21));
    return s;
  endfunction

  // Offer one beat and hold it until the core takes it. Valid stays high on
  // return so back-to-back beats never drop it in between.
  task automatic send_snapshot(input snapshot_t s, input idle_mode_t mode);
    while (sender_holds(mode)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cur_snap <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every expected result has come back, then
  // let the pipe settle. The pending count is read on the falling edge so
  // it never races the monitor.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle until pready, then the bus idles
  // before return, so back-to-back writes never drive the bus twice at one edge.
  task automatic write_reg(input cfg_reg_e_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input bit bcd, input bit twelve_hr, input bit century,
                           input logic [31:0] base);
    write_reg(REG_BCD_MODE, {31'd0, bcd});
    write_reg(REG_TWELVE_HOUR, {31'd0, twelve_hr});
    write_reg(REG_CENTURY_VALID, {31'd0, century});
    write_reg(REG_BASE_YEAR, base);
  endtask

  task automatic run_directed();
    // reset settings: BCD, 24-hour, base year 2000
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), IDLE_NONE);
    send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), IDLE_NONE);
    send_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99, 8'h20), IDLE_NONE);
    // leap day and the day after it
    send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h04, 8'h29, 8'h02, 8'h24, 8'h20), IDLE_NONE);
    send_snapshot(snap(8'h01, 8'h02, 8'h03, 8'h05, 8'h01, 8'h03, 8'h24, 8'h20), IDLE_NONE);
    // month 13 and beyond
    send_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h01, 8'h01, 8'h13, 8'h23, 8'h20), IDLE_NONE);
    send_snapshot(snap(8'h10, 8'h20, 8'h05, 8'h01, 8'h05, 8'h14, 8'h24, 8'h20), IDLE_NONE);
    // nibbles above nine go through the decode as they are
    send_snapshot(snap(8'h9A, 8'hAB, 8'hFA, 8'hBC, 8'h3F, 8'h0C, 8'hAA, 8'h20), IDLE_NONE);
    // century byte must be ignored while century_valid is clear
    send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h04, 8'h29, 8'h02, 8'h24, 8'hFF), IDLE_NONE);
    wait_all_results();

    configure(1'b1, 1'b1, 1'b1, 32'd0);
    // 1969 gives zero seconds, 1970-01-01 12 AM is exactly zero too
    send_snapshot(snap(8'h59, 8'h59, 8'h11, 8'h01, 8'h31, 8'h12, 8'h69, 8'h19), IDLE_NONE);
    send_snapshot(snap(8'h00, 8'h00, 8'h12, 8'h04, 8'h01, 8'h01, 8'h70, 8'h19), IDLE_NONE);
    send_snapshot(snap(8'h00, 8'h00, 8'h92, 8'h06, 8'h15, 8'h06, 8'h00, 8'h20), IDLE_NONE);
    send_snapshot(snap(8'h30, 8'h15, 8'h81, 8'h06, 8'h15, 8'h06, 8'h00, 8'h20), IDLE_NONE);
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h20), IDLE_NONE);
    send_snapshot(snap(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h01, 8'hFF, 8'hFF), IDLE_NONE);
    send_snapshot(snap(8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00), IDLE_NONE);
    wait_all_results();

    // binary bytes, top of the base year field, 12-hour edges
    configure(1'b0, 1'b1, 1'b0, 32'd16383);
    send_snapshot(snap(8'd59, 8'd59, 8'h8C, 8'd7, 8'd31, 8'd12, 8'hFF, 8'h00), IDLE_NONE);
    send_snapshot(snap(8'd0, 8'd0, 8'h0C, 8'd1, 8'd1, 8'd1, 8'd0, 8'h00), IDLE_NONE);
    send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), IDLE_NONE);
    wait_all_results();

    // base year zero: every year is before 1970
    configure(1'b0, 1'b0, 1'b0, 32'd0);
    send_snapshot(snap(8'd10, 8'd20, 8'd13, 8'd3, 8'd4, 8'd5, 8'd255, 8'd20), IDLE_NONE);
    send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), IDLE_NONE);
    wait_all_results();
  endtask

  // Mostly plausible readings, the rest pure noise. Halfway through, the
  // sender pauses until the core has returned every result.
  task automatic run_random(input idle_mode_t mode, input int count);
    idle_mode <= mode;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_all_results();
      if ($urandom_range(9) < 7)
        send_snapshot(plausible_snapshot(), mode);
      else
        send_snapshot(snapshot_t'({$urandom(), $urandom()}), mode);
    end
    wait_all_results();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    configure(1'b1, 1'b0, 1'b0, 32'd2000);
    run_random(IDLE_NONE, 150);
    configure(1'b1, 1'b1, 1'b1, 32'd0);
    run_random(IDLE_SEND, 150);
    // junk above the 14-bit field must be dropped
    configure(1'b0, 1'b0, 1'b0, 32'hFFFF_C000 | 32'd1970);
    run_random(IDLE_RECV, 150);
    configure(1'b0, 1'b1, 1'b0, 32'd9900);
    run_random(IDLE_BOTH, 150);
    configure(1'b1, 1'b0, 1'b0, 32'd16383);
    run_random(IDLE_BACKLOG, 100);
    // base 1900 puts two-digit years on both sides of 1970
    configure(1'b1, 1'b1, 1'b0, 32'd1900);
    run_random(IDLE_BOTH, 150);
    configure(1'b0, 1'b0, 1'b1, 32'd0);
    run_random(IDLE_NONE, 150);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
